// ===== rtl/core/ptb_pkg.sv =====
// shared types, constants and helpers for the periodic timer bank
package ptb_pkg;

  localparam int unsigned NUM_TIMERS = 8;
  localparam int unsigned ID_W       = 5;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned MASK_IDX_W = 3;

  // first id that is out of range
  localparam logic [ID_W:0]   NUM_LIMIT  = NUM_TIMERS[ID_W:0];
  // cells at or above this index have no bit in the fired mask
  localparam logic [ID_W-1:0] MASK_LIMIT = MASK_W[ID_W-1:0];

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_START  = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_ID         = 3'd1,
    ST_ZERO_PERIOD    = 3'd2,
    ST_CONFLICT       = 3'd3,
    ST_NOT_CONFIGURED = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] interval_ms;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] fired_mask;
    status_t           status;
  } out_item_t;

  // transaction travelling down the row of timer cells
  typedef struct packed {
    logic              valid;
    cmd_t              command;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] interval_ms;
    logic [TIME_W-1:0] now_ms;
    logic [MASK_W-1:0] fired_mask;
    status_t           status;
  } tok_t;

  function automatic logic [ID_W-1:0] cell_index(input int unsigned n);
    return n[ID_W-1:0];
  endfunction

endpackage

// ===== rtl/core/ptb_cell.sv =====
// one timer cell: holds a single timer and updates the passing transaction
module ptb_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ptb_pkg::ID_W-1:0]  cell_idx,
  input  logic                      advance,
  input  ptb_pkg::tok_t             tok_i,
  output ptb_pkg::tok_t             tok_o
);

  logic [ptb_pkg::TIME_W-1:0] period_r, period_nxt;
  logic [ptb_pkg::TIME_W-1:0] last_r, last_nxt;
  logic                       running_r, running_nxt;
  logic                       configured_r, configured_nxt;
  ptb_pkg::tok_t              tok_r, tok_nxt;

  logic                       id_match;
  logic [ptb_pkg::TIME_W-1:0] elapsed;

  assign id_match = (tok_i.timer_id == cell_idx);
  // modulo 2^32 difference
  assign elapsed  = tok_i.now_ms - last_r;

  always_comb begin
    period_nxt     = period_r;
    last_nxt       = last_r;
    running_nxt    = running_r;
    configured_nxt = configured_r;
    tok_nxt        = tok_r;
    if (advance) begin
      tok_nxt = tok_i;
      if (tok_i.valid) begin
        case (tok_i.command)
          ptb_pkg::CMD_TICK: begin
            if (running_r && (elapsed >= period_r)) begin
              last_nxt = tok_i.now_ms;
              if (cell_idx < ptb_pkg::MASK_LIMIT) begin
                tok_nxt.fired_mask[cell_idx[ptb_pkg::MASK_IDX_W-1:0]] = 1'b1;
              end
            end
          end
          ptb_pkg::CMD_CREATE: begin
            if (id_match) begin
              if (tok_i.interval_ms == '0) begin
                tok_nxt.status = ptb_pkg::ST_ZERO_PERIOD;
              end else if (running_r) begin
                if (period_r != tok_i.interval_ms) begin
                  tok_nxt.status = ptb_pkg::ST_CONFLICT;
                end
              end else begin
                period_nxt     = tok_i.interval_ms;
                configured_nxt = 1'b1;
              end
            end
          end
          ptb_pkg::CMD_START: begin
            if (id_match) begin
              if (!configured_r) begin
                tok_nxt.status = ptb_pkg::ST_NOT_CONFIGURED;
              end else begin
                last_nxt    = tok_i.now_ms;
                running_nxt = 1'b1;
              end
            end
          end
          ptb_pkg::CMD_STOP: begin
            if (id_match) begin
              running_nxt = 1'b0;
            end
          end
          default: begin
            tok_nxt = tok_i;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid  <= 1'b0;
      running_r    <= 1'b0;
      configured_r <= 1'b0;
    end else begin
      tok_r        <= tok_nxt;
      running_r    <= running_nxt;
      configured_r <= configured_nxt;
    end
  end

  // period and last-fire time only matter once configured and running
  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    last_r   <= last_nxt;
  end

  assign tok_o = tok_r;

endmodule

// ===== rtl/core/periodic_timer_bank_core.sv =====
// periodic timer bank top level: injects transactions into a row of timer cells
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------------
//   input   | in_valid / in_ready   | in_data  (command, timer_id, interval_ms, now_ms)
//   result  | out_valid / out_ready | out_data (fired_mask, status)
//
// a transaction enters cell 0 on acceptance and moves one cell per cycle while the row
// is not stalled; after the last cell its result is registered in the output register
// one transaction is in the row at a time; in_ready rises together with out_valid, so
// the next item is accepted only once the previous one has left the row
// a result waiting in the output register does not block the next item; the row
// only stalls when a second result is ready while the first is still not taken
// rst_n is synchronous and clears all timers to stopped and unconfigured
module periodic_timer_bank_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ptb_pkg::out_item_t out_data
);

  ptb_pkg::tok_t              chain [ptb_pkg::NUM_TIMERS+1];
  ptb_pkg::tok_t              tok_head;
  ptb_pkg::tok_t              tok_last;
  logic [ptb_pkg::NUM_TIMERS-1:0] cell_valid;

  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  ptb_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_accept;
  logic bad_id;
  logic move;
  logic advance;

  assign in_ready  = !busy_r;
  assign in_accept = in_valid && in_ready;
  assign bad_id    = (in_data.command != ptb_pkg::CMD_TICK) &&
                     ({1'b0, in_data.timer_id} >= ptb_pkg::NUM_LIMIT);

  always_comb begin
    tok_head.valid       = in_accept;
    tok_head.command     = in_data.command;
    tok_head.timer_id    = in_data.timer_id;
    tok_head.interval_ms = in_data.interval_ms;
    tok_head.now_ms      = in_data.now_ms;
    tok_head.fired_mask  = '0;
    tok_head.status      = bad_id ? ptb_pkg::ST_BAD_ID : ptb_pkg::ST_OK;
  end

  assign chain[0] = tok_head;

  genvar gi;
  generate
    for (gi = 0; gi < ptb_pkg::NUM_TIMERS; gi++) begin : g_cell
      ptb_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (ptb_pkg::cell_index(gi)),
        .advance  (advance),
        .tok_i    (chain[gi]),
        .tok_o    (chain[gi+1])
      );
      assign cell_valid[gi] = chain[gi+1].valid;
    end
  endgenerate

  assign tok_last = chain[ptb_pkg::NUM_TIMERS];
  // the last cell hands its result to the output register when there is room
  assign move     = tok_last.valid && (!out_valid_r || out_ready);
  assign advance  = !tok_last.valid || move;

  always_comb begin
    busy_nxt = busy_r;
    if (in_accept) begin
      busy_nxt = 1'b1;
    end else if (move) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (move) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.fired_mask = tok_last.fired_mask;
      out_data_nxt.status     = tok_last.status;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // at most one transaction travels the row
  a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) <= 1)
    else $error("more than one transaction in the timer row");

  // a transaction is only in the row while the block is busy
  a_token_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cell_valid == '0))
    else $error("transaction in the row while idle");

  // an accepted transaction shows up in the first cell
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (busy_r && cell_valid[0]))
    else $error("accepted transaction did not enter the row");

  // a result handed over is presented on the next cycle
  a_move_presents: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> (out_valid && !busy_r))
    else $error("result not presented after leaving the row");

endmodule
